FILE: hw/rtl/hbp_pkg.sv
// Shared constants and types of the hybrid branch predictor.
// No dependencies; compile first.
`default_nettype none

package hbp_pkg;

  // Pattern index takes this many bits of pc and history together.
  localparam int unsigned PC_INDEX_SPAN     = 16;
  localparam int unsigned FALL_THROUGH_STEP = 1;
  localparam int unsigned STAMP_W           = 64;

  typedef enum logic {
    OP_PREDICT = 1'b0,
    OP_UPDATE  = 1'b1
  } op_e;

  localparam logic [1:0] KIND_COND   = 2'd1;
  localparam logic [1:0] KIND_UNCOND = 2'd2;

  localparam logic [1:0] CONF_STRONG_NOT   = 2'd0;
  localparam logic [1:0] CONF_WEAK_NOT     = 2'd1;
  localparam logic [1:0] CONF_STRONG_TAKEN = 2'd3;

  // Register index carried by address bit 2.
  localparam logic REG_PREDICT_ENABLE = 1'b0;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_SCAN  = 4'b1000
  } state_e;

endpackage

`default_nettype wire

FILE: hw/rtl/hbp_if.sv
// Request and response channels of the branch predictor.
// No dependencies besides the valid/ready convention.
`default_nettype none

interface hbp_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] branch_pc;
  logic [1:0]  branch_kind;
  logic        resolved_taken;
  logic [31:0] resolved_target;

  modport source (output valid, opcode, branch_pc, branch_kind, resolved_taken,
                  resolved_target, input ready);
  modport sink   (input valid, opcode, branch_pc, branch_kind, resolved_taken,
                  resolved_target, output ready);
endinterface

interface hbp_rsp_if;
  logic        valid;
  logic        ready;
  logic        forecast_taken;
  logic [31:0] forecast_target;
  logic [1:0]  confidence;
  logic        hit_btb;

  modport source (output valid, forecast_taken, forecast_target, confidence,
                  hit_btb, input ready);
  modport sink   (input valid, forecast_taken, forecast_target, confidence,
                  hit_btb, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/hybrid_branch_predictor_btb.sv
// Hybrid branch predictor top level: pattern table, local histories, BTB.
// Depends on hbp_pkg and the channel interfaces in hbp_if.sv.
//
// One request is handled at a time. A request is taken in the idle state
// while the pattern table and local history memories are read, and most
// are finished in the read state from their registered read data; a
// predict waits there until the output register is free. A taken update
// that must evict a BTB entry while every entry is valid walks the age
// stamps, one entry per cycle. Predict results sit in an output register,
// so a new request is taken while a result still waits. After reset, a
// clearing pass writes the pattern table to weak not taken and the local
// histories to zero, one entry per cycle; no request is taken meanwhile,
// but configuration writes are. All table sizes must be powers of two.
// Register 0 (predict_enable, address 0) resets to 1.
`default_nettype none

module hybrid_branch_predictor_btb #(
  parameter int unsigned PATTERN_ENTRIES = 4096,
  parameter int unsigned TARGET_ENTRIES  = 16,
  parameter int unsigned GLOBAL_BITS     = 8,
  parameter int unsigned LOCAL_BITS      = 8,
  parameter int unsigned LOCAL_ENTRIES   = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  hbp_req_if.sink          req_i,
  hbp_rsp_if.source        rsp_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import hbp_pkg::*;

  localparam int unsigned PW    = $clog2(PATTERN_ENTRIES);
  localparam int unsigned LW    = $clog2(LOCAL_ENTRIES);
  localparam int unsigned TW    = $clog2(TARGET_ENTRIES);
  localparam int unsigned CLR_N = (PATTERN_ENTRIES > LOCAL_ENTRIES) ?
                                  PATTERN_ENTRIES : LOCAL_ENTRIES;
  localparam int unsigned CW    = $clog2(CLR_N);
  localparam int unsigned PCP   = PC_INDEX_SPAN - GLOBAL_BITS;

  // Lowest set bit of a vector; zero when empty.
  function automatic logic [TW-1:0] lowest(input logic [TARGET_ENTRIES-1:0] v);
    logic [TW-1:0] idx;
    idx = '0;
    for (int i = TARGET_ENTRIES - 1; i >= 0; i--) begin
      if (v[i]) idx = TW'(i);
    end
    return idx;
  endfunction

  // ---------------------------------------------------------------------
  // Control and item registers
  // ---------------------------------------------------------------------
  state_e                 st_q, st_d;
  logic [CW-1:0]          clr_q, clr_d;
  logic                   enable_q;
  logic [GLOBAL_BITS-1:0] ghr_q, ghr_d;
  logic [STAMP_W-1:0]     stamp_cnt_q, stamp_cnt_d;

  logic                   opcode_q;
  logic [31:0]            pc_q;
  logic [1:0]             kind_q;
  logic                   taken_q;
  logic [31:0]            target_q;

  // ---------------------------------------------------------------------
  // Pattern table and local history memories
  // ---------------------------------------------------------------------
  logic [1:0]            pht_mem [PATTERN_ENTRIES];
  logic                  pht_we, pht_re;
  logic [PW-1:0]         pht_waddr, pht_raddr;
  logic [1:0]            pht_wdata, pht_rdata_q;

  logic [LOCAL_BITS-1:0] lht_mem [LOCAL_ENTRIES];
  logic                  lht_we, lht_re;
  logic [LW-1:0]         lht_waddr, lht_raddr;
  logic [LOCAL_BITS-1:0] lht_wdata, lht_rdata_q;

  always_ff @(posedge clk_i) begin
    if (pht_we) pht_mem[pht_waddr] <= pht_wdata;
    if (pht_re) pht_rdata_q <= pht_mem[pht_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (lht_we) lht_mem[lht_waddr] <= lht_wdata;
    if (lht_re) lht_rdata_q <= lht_mem[lht_raddr];
  end

  // ---------------------------------------------------------------------
  // BTB: valid bits reset, the rest written before use
  // ---------------------------------------------------------------------
  logic [TARGET_ENTRIES-1:0] valid_q;
  logic [31:0]               tag_q   [TARGET_ENTRIES];
  logic [31:0]               addr_q  [TARGET_ENTRIES];
  logic [STAMP_W-1:0]        stamp_q [TARGET_ENTRIES];

  logic                      btb_we;
  logic [TW-1:0]             btb_widx;
  logic                      stamp_we;
  logic [TW-1:0]             stamp_widx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (btb_we) begin
      valid_q[btb_widx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (btb_we) begin
      tag_q[btb_widx]  <= pc_q;
      addr_q[btb_widx] <= target_q;
    end
    if (stamp_we) stamp_q[stamp_widx] <= stamp_cnt_d;
  end

  // Eviction walk state.
  logic [TW-1:0]      scan_q, scan_d;
  logic [TW-1:0]      vic_q, vic_d;
  logic [STAMP_W-1:0] min_q, min_d;
  logic [STAMP_W-1:0] home_st_q, home_st_d;
  logic [STAMP_W-1:0] scan_rd;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic        out_load;
  logic        out_taken_q, out_taken_d;
  logic [31:0] out_target_q, out_target_d;
  logic [1:0]  out_conf_q, out_conf_d;
  logic        out_hit_q, out_hit_d;

  // ---------------------------------------------------------------------
  // Datapath of the finishing cycle
  // ---------------------------------------------------------------------
  logic                      active;
  logic                      majority;
  logic                      pred_taken;
  logic [1:0]                pred_conf;
  logic [TW-1:0]             home;
  logic [TARGET_ENTRIES-1:0] match, low_mask, match_hi;
  logic                      hit;
  logic [TW-1:0]             hit_idx;
  logic                      home_free;
  logic                      any_free;
  logic [TW-1:0]             first_free;
  logic [PW-1:0]             pidx_req, pidx_item;
  logic [1:0]                ctr_next;

  assign pidx_req  = PW'({req_i.branch_pc[PCP-1:0], ghr_q});
  assign pidx_item = PW'({pc_q[PCP-1:0], ghr_q});

  assign active   = enable_q && (kind_q == KIND_COND || kind_q == KIND_UNCOND);
  assign majority = $countones(lht_rdata_q) > (LOCAL_BITS / 2);

  always_comb begin
    if (kind_q == KIND_UNCOND) begin
      pred_taken = 1'b1;
      pred_conf  = CONF_STRONG_TAKEN;
    end else begin
      pred_conf = pht_rdata_q;
      if (pht_rdata_q == CONF_STRONG_TAKEN)     pred_taken = 1'b1;
      else if (pht_rdata_q == CONF_STRONG_NOT)  pred_taken = 1'b0;
      else                                      pred_taken = majority;
    end
  end

  // Saturating counter training.
  always_comb begin
    ctr_next = pht_rdata_q;
    if (taken_q) begin
      if (pht_rdata_q != CONF_STRONG_TAKEN) ctr_next = pht_rdata_q + 2'd1;
    end else begin
      if (pht_rdata_q != CONF_STRONG_NOT) ctr_next = pht_rdata_q - 2'd1;
    end
  end

  // Tag match in probe order: first hit at or above home, else wrap.
  assign home = pc_q[TW-1:0];
  always_comb begin
    for (int i = 0; i < TARGET_ENTRIES; i++) begin
      match[i] = valid_q[i] && (tag_q[i] == pc_q);
    end
  end
  assign low_mask   = (TARGET_ENTRIES'(1) << home) - TARGET_ENTRIES'(1);
  assign match_hi   = match & ~low_mask;
  assign hit        = |match;
  assign hit_idx    = (|match_hi) ? lowest(match_hi) : lowest(match);
  assign home_free  = !valid_q[home] || match[home];
  assign any_free   = ~&valid_q;
  assign first_free = lowest(~valid_q);

  // Eviction walk: track minimum, its lowest index, and home's stamp.
  assign scan_rd = stamp_q[scan_q];
  always_comb begin
    min_d     = min_q;
    vic_d     = vic_q;
    home_st_d = home_st_q;
    if (scan_q == '0 || scan_rd < min_q) begin
      min_d = scan_rd;
      vic_d = scan_q;
    end
    if (scan_q == home) home_st_d = scan_rd;
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  assign req_i.ready = (st_q == ST_IDLE);

  always_comb begin
    st_d        = st_q;
    clr_d       = clr_q;
    ghr_d       = ghr_q;
    stamp_cnt_d = stamp_cnt_q;
    scan_d      = scan_q;

    pht_we    = 1'b0;
    pht_waddr = pidx_item;
    pht_wdata = ctr_next;
    pht_re    = 1'b0;
    pht_raddr = pidx_req;
    lht_we    = 1'b0;
    lht_waddr = pc_q[LW-1:0];
    lht_wdata = LOCAL_BITS'({lht_rdata_q, taken_q});
    lht_re    = 1'b0;
    lht_raddr = req_i.branch_pc[LW-1:0];

    btb_we     = 1'b0;
    btb_widx   = home;
    stamp_we   = 1'b0;
    stamp_widx = home;

    out_load     = 1'b0;
    out_taken_d  = 1'b0;
    out_target_d = '0;
    out_conf_d   = CONF_STRONG_NOT;
    out_hit_d    = 1'b0;

    case (st_q)
      ST_CLEAR: begin
        // Sweep both tables to their reset contents.
        pht_we    = 32'(clr_q) < PATTERN_ENTRIES;
        pht_waddr = clr_q[PW-1:0];
        pht_wdata = CONF_WEAK_NOT;
        lht_we    = 32'(clr_q) < LOCAL_ENTRIES;
        lht_waddr = clr_q[LW-1:0];
        lht_wdata = '0;
        clr_d     = clr_q + CW'(1);
        if (clr_q == CW'(CLR_N - 1)) st_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_i.valid) begin
          pht_re = 1'b1;
          lht_re = 1'b1;
          st_d   = ST_READ;
        end
      end
      ST_READ: begin
        if (opcode_q == OP_UPDATE) begin
          st_d = ST_IDLE;
          if (active) begin
            pht_we = 1'b1;
            lht_we = 1'b1;
            ghr_d  = GLOBAL_BITS'({ghr_q, taken_q});
            if (taken_q) begin
              if (home_free || any_free) begin
                btb_we      = 1'b1;
                btb_widx    = home_free ? home : first_free;
                stamp_we    = 1'b1;
                stamp_widx  = btb_widx;
                stamp_cnt_d = stamp_cnt_q + STAMP_W'(1);
              end else begin
                // All entries valid: find the oldest stamp.
                scan_d = '0;
                st_d   = ST_SCAN;
              end
            end
          end
        end else if (!out_valid_q || rsp_o.ready) begin
          // Hold until the output register is free.
          out_load = 1'b1;
          st_d     = ST_IDLE;
          if (active) begin
            out_taken_d = pred_taken;
            out_conf_d  = pred_conf;
            if (pred_taken) begin
              out_hit_d    = hit;
              out_target_d = hit ? addr_q[hit_idx] : '0;
              if (hit) begin
                stamp_we    = 1'b1;
                stamp_widx  = hit_idx;
                stamp_cnt_d = stamp_cnt_q + STAMP_W'(1);
              end
            end else begin
              out_target_d = pc_q + 32'(FALL_THROUGH_STEP);
            end
          end
        end
      end
      ST_SCAN: begin
        scan_d = scan_q + TW'(1);
        if (scan_q == TW'(TARGET_ENTRIES - 1)) begin
          btb_we      = 1'b1;
          btb_widx    = (home_st_d == min_d) ? home : vic_d;
          stamp_we    = 1'b1;
          stamp_widx  = btb_widx;
          stamp_cnt_d = stamp_cnt_q + STAMP_W'(1);
          st_d        = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (rsp_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLEAR;
      clr_q       <= '0;
      ghr_q       <= '0;
      stamp_cnt_q <= '0;
      out_valid_q <= 1'b0;
      scan_q      <= '0;
    end else begin
      st_q        <= st_d;
      clr_q       <= clr_d;
      ghr_q       <= ghr_d;
      stamp_cnt_q <= stamp_cnt_d;
      out_valid_q <= out_valid_d;
      scan_q      <= scan_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      opcode_q <= req_i.opcode;
      pc_q     <= req_i.branch_pc;
      kind_q   <= req_i.branch_kind;
      taken_q  <= req_i.resolved_taken;
      target_q <= req_i.resolved_target;
    end
    if (st_q == ST_SCAN) begin
      min_q     <= min_d;
      vic_q     <= vic_d;
      home_st_q <= home_st_d;
    end
    if (out_load) begin
      out_taken_q  <= out_taken_d;
      out_target_q <= out_target_d;
      out_conf_q   <= out_conf_d;
      out_hit_q    <= out_hit_d;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.forecast_taken  = out_taken_q;
  assign rsp_o.forecast_target = out_target_q;
  assign rsp_o.confidence      = out_conf_q;
  assign rsp_o.hit_btb         = out_hit_q;

  // ---------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == REG_PREDICT_ENABLE) begin
      enable_q <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PREDICT_ENABLE) ? {31'd0, enable_q} : 32'd0;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request taken while another is in flight");

  a_stamp_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stamp_cnt_q != $past(stamp_cnt_q) |-> stamp_cnt_q == $past(stamp_cnt_q) + 64'd1)
    else $error("stamp counter moved by more than one");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(st_q) == ST_READ)
    else $error("result loaded outside the finishing cycle");

  a_valid_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) >= $countones($past(valid_q)))
    else $error("BTB entry lost its valid bit");

endmodule

`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for the hybrid branch predictor with BTB.
// Depends on hbp_pkg, the channel interfaces in hbp_if.sv and the top level.
`default_nettype none

module testbench;
  import hbp_pkg::*;

  localparam int unsigned PAT_N   = 4096;
  localparam int unsigned TGT_N   = 16;
  localparam int unsigned GH_BITS = 8;
  localparam int unsigned LH_BITS = 8;
  localparam int unsigned LH_N    = 1024;
  localparam int unsigned N_RANDOM = 1520;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    op_e         opcode;
    logic [31:0] branch_pc;
    logic [1:0]  branch_kind;
    logic        resolved_taken;
    logic [31:0] resolved_target;
  } request_t;

  typedef struct packed {
    logic        forecast_taken;
    logic [31:0] forecast_target;
    logic [1:0]  confidence;
    logic        hit_btb;
  } prediction_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  hbp_req_if req_ch ();
  hbp_rsp_if rsp_ch ();

  hybrid_branch_predictor_btb u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch.sink),
    .rsp_o  (rsp_ch.source),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the predictor state.
  logic [1:0]         pht      [PAT_N];
  logic [LH_BITS-1:0] lhist    [LH_N];
  logic [GH_BITS-1:0] ghist;
  logic               btb_vld  [TGT_N];
  logic [31:0]        btb_tag  [TGT_N];
  logic [31:0]        btb_dst  [TGT_N];
  logic [63:0]        btb_age  [TGT_N];
  logic [63:0]        age_clock;
  logic               enable_shadow;

  request_t    pending_reqs[$];
  prediction_t expected_preds[$];

  int  mismatches = 0;
  int  predicts_seen = 0;
  int  updates_sent = 0;
  int  sent_count = 0;
  bit  hold_rsp = 1'b0;
  bit  hold_start = 1'b0;
  longint cycle_count = 0;

  function automatic int unsigned pht_index(logic [31:0] pc);
    logic [31:0] pc_part;
    pc_part = pc & ((32'd1 << (PC_INDEX_SPAN - GH_BITS)) - 1);
    return ((pc_part << GH_BITS) | ghist) % PAT_N;
  endfunction

  function automatic bool_majority(logic [31:0] pc);
    int ones;
    ones = $countones(lhist[pc % LH_N]);
    return ones > (LH_BITS / 2);
  endfunction

  function automatic void btb_store(int unsigned s, logic [31:0] pc, logic [31:0] dst);
    age_clock++;
    btb_vld[s] = 1'b1;
    btb_tag[s] = pc;
    btb_dst[s] = dst;
    btb_age[s] = age_clock;
  endfunction

  function automatic void btb_allocate(logic [31:0] pc, logic [31:0] dst);
    int unsigned home, victim;
    logic [63:0] oldest;
    home = pc % TGT_N;
    if (!btb_vld[home] || btb_tag[home] == pc) begin
      btb_store(home, pc, dst);
      return;
    end
    victim = home;
    oldest = btb_age[home];
    for (int i = 0; i < TGT_N; i++) begin
      if (!btb_vld[i]) begin
        btb_store(i, pc, dst);
        return;
      end
      if (btb_age[i] < oldest) begin
        victim = i;
        oldest = btb_age[i];
      end
    end
    btb_store(victim, pc, dst);
  endfunction

  function automatic void btb_fetch(logic [31:0] pc, ref prediction_t p);
    int unsigned s;
    for (int i = 0; i < TGT_N; i++) begin
      s = (pc + i) % TGT_N;
      if (btb_vld[s] && btb_tag[s] == pc) begin
        age_clock++;
        btb_age[s] = age_clock;
        p.forecast_target = btb_dst[s];
        p.hit_btb = 1'b1;
        return;
      end
    end
  endfunction

  // Advance the shadow state by one request; queue a prediction for predicts.
  function automatic void predict_branch(request_t r);
    prediction_t p;
    logic active;
    int unsigned ps;
    logic [1:0] c;
    p = '0;
    active = enable_shadow && (r.branch_kind == KIND_COND || r.branch_kind == KIND_UNCOND);
    if (r.opcode == OP_UPDATE) begin
      if (active) begin
        ps = pht_index(r.branch_pc);
        c = pht[ps];
        if (r.resolved_taken) begin
          if (c != 2'd3) c++;
        end else if (c != 2'd0) begin
          c--;
        end
        pht[ps] = c;
        lhist[r.branch_pc % LH_N] = {lhist[r.branch_pc % LH_N][LH_BITS-2:0], r.resolved_taken};
        ghist = {ghist[GH_BITS-2:0], r.resolved_taken};
        if (r.resolved_taken) btb_allocate(r.branch_pc, r.resolved_target);
      end
      return;
    end
    if (active) begin
      if (r.branch_kind == KIND_UNCOND) begin
        p.forecast_taken = 1'b1;
        p.confidence = CONF_STRONG_TAKEN;
        btb_fetch(r.branch_pc, p);
      end else begin
        c = pht[pht_index(r.branch_pc)];
        p.confidence = c;
        if (c == CONF_STRONG_NOT || c == CONF_STRONG_TAKEN)
          p.forecast_taken = (c == CONF_STRONG_TAKEN);
        else
          p.forecast_taken = bool_majority(r.branch_pc);
        if (p.forecast_taken) btb_fetch(r.branch_pc, p);
        else p.forecast_target = r.branch_pc + FALL_THROUGH_STEP;
      end
    end
    expected_preds.push_back(p);
  endfunction

  // Driver: hold each request until its transfer, then draw a gap.
  int unsigned req_gap = 0;
  request_t cur_req;
  initial begin
    req_ch.valid = 1'b0;
    req_ch.opcode = 1'b0;
    req_ch.branch_pc = '0;
    req_ch.branch_kind = '0;
    req_ch.resolved_taken = 1'b0;
    req_ch.resolved_target = '0;
  end
  bit drive_on = 1'b0;
  always @(posedge clk_i) begin
    if (req_ch.valid && req_ch.ready) begin
      predict_branch(cur_req);
      sent_count++;
      if (cur_req.opcode == OP_UPDATE) updates_sent++;
      req_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 13) : 0;
    end
    if (drive_on && pending_reqs.size() > 0 && req_gap == 0 &&
        !(req_ch.valid && !req_ch.ready)) begin
      cur_req = pending_reqs.pop_front();
      req_ch.valid           <= 1'b1;
      req_ch.opcode          <= cur_req.opcode;
      req_ch.branch_pc       <= cur_req.branch_pc;
      req_ch.branch_kind     <= cur_req.branch_kind;
      req_ch.resolved_taken  <= cur_req.resolved_taken;
      req_ch.resolved_target <= cur_req.resolved_target;
    end else if (!(req_ch.valid && !req_ch.ready)) begin
      req_ch.valid <= 1'b0;
      if (req_gap > 0) req_gap--;
    end
  end

  // Monitor: random backpressure, with an occasional long hold-off.
  int unsigned rsp_gap = 0;
  initial rsp_ch.ready = 1'b0;
  always @(posedge clk_i) begin
    prediction_t got, want;
    if (rsp_ch.valid && rsp_ch.ready) begin
      got = {rsp_ch.forecast_taken, rsp_ch.forecast_target, rsp_ch.confidence,
             rsp_ch.hit_btb};
      predicts_seen++;
      if (expected_preds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected prediction %h", got);
      end else begin
        want = expected_preds.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"prediction mismatch: expected taken=%0b target=%h conf=%0d hit=%0b,",
                      " got taken=%0b target=%h conf=%0d hit=%0b"},
                     want.forecast_taken, want.forecast_target, want.confidence,
                     want.hit_btb, got.forecast_taken, got.forecast_target,
                     got.confidence, got.hit_btb);
        end
      end
      rsp_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 13) : 0;
    end else if (rsp_gap > 0) begin
      rsp_gap--;
    end
    rsp_ch.ready <= !hold_rsp && (rsp_gap == 0);
  end

  // Long receiver hold-off, counted here once started.
  initial begin
    wait (hold_start);
    hold_rsp = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_rsp = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // Two-phase APB write; the register takes the value at the access edge.
  task automatic reg_write(logic reg_idx, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00}; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    enable_shadow = value[0];
  endtask

  // Wait for all transfers to settle, plus slack for an eviction walk.
  task automatic drain();
    while (pending_reqs.size() > 0 || req_ch.valid || expected_preds.size() > 0)
      @(posedge clk_i);
    repeat (TGT_N + 8) @(posedge clk_i);
  endtask

  function automatic request_t make_req(op_e op, logic [31:0] pc, logic [1:0] kind,
                                        logic tk, logic [31:0] dst);
    request_t r;
    r.opcode = op; r.branch_pc = pc; r.branch_kind = kind;
    r.resolved_taken = tk; r.resolved_target = dst;
    return r;
  endfunction

  // A few hot branch sites with occasional far-off ones.
  function automatic logic [31:0] pick_pc();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
      default: return 32'h0000_4000 + $urandom_range(0, 47);
    endcase
  endfunction

  function automatic request_t random_req();
    logic [1:0] kind;
    logic [31:0] pc;
    kind = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) :
           (($urandom_range(0, 3) == 0) ? KIND_UNCOND : KIND_COND);
    pc = pick_pc();
    return make_req(op_e'($urandom_range(0, 1)), pc, kind, 1'($urandom_range(0, 2) != 0),
                    $urandom());
  endfunction

  initial begin
    ghist = '0; age_clock = '0; enable_shadow = 1'b1;
    foreach (pht[i]) pht[i] = 2'd1;
    foreach (lhist[i]) lhist[i] = '0;
    foreach (btb_vld[i]) begin
      btb_vld[i] = 1'b0; btb_tag[i] = '0; btb_dst[i] = '0; btb_age[i] = '0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, every kind, strong and weak counters, fall-through wrap.
    reg_write(REG_PREDICT_ENABLE, 32'd1);
    drive_on = 1'b1;
    pending_reqs.push_back(make_req(OP_PREDICT, 32'hFFFF_FFFF, KIND_COND, 1'b0, '0));
    pending_reqs.push_back(make_req(OP_PREDICT, 32'h0, KIND_UNCOND, 1'b0, '0));
    pending_reqs.push_back(make_req(OP_PREDICT, 32'h5, 2'd0, 1'b1, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(OP_PREDICT, 32'h5, 2'd3, 1'b1, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(OP_UPDATE, 32'h7, 2'd3, 1'b1, 32'h1234));
    for (int i = 0; i < 6; i++)
      pending_reqs.push_back(make_req(OP_UPDATE, 32'h7, KIND_COND, 1'b1, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(OP_PREDICT, 32'h7, KIND_COND, 1'b0, '0));
    pending_reqs.push_back(make_req(OP_PREDICT, 32'h7, KIND_UNCOND, 1'b0, '0));
    for (int i = 0; i < 4; i++)
      pending_reqs.push_back(make_req(OP_UPDATE, 32'h9, KIND_UNCOND, 1'b0, '0));
    pending_reqs.push_back(make_req(OP_PREDICT, 32'h9, KIND_COND, 1'b0, '0));
    pending_reqs.push_back(make_req(OP_UPDATE, 32'hFFFF_FFFF, KIND_UNCOND, 1'b1, 32'h0));
    pending_reqs.push_back(make_req(OP_PREDICT, 32'hFFFF_FFFF, KIND_UNCOND, 1'b0, '0));
    pending_reqs.push_back(make_req(OP_UPDATE, 32'h8000_0000, KIND_COND, 1'b0, 32'hAAAA_5555));
    drain();

    // Disabled: everything acts as a non-branch.
    reg_write(REG_PREDICT_ENABLE, 32'd0);
    for (int i = 0; i < 60; i++) pending_reqs.push_back(random_req());
    drain();
    reg_write(REG_PREDICT_ENABLE, 32'hFFFF_FFFF);

    // Random phases; the first one blocks the receiver to fill the block.
    for (int ph = 0; ph < 4; ph++) begin
      for (int i = 0; i < N_RANDOM / 4; i++) pending_reqs.push_back(random_req());
      if (ph == 0) hold_start = 1'b1;
      drain();
      if (ph == 2) begin
        reg_write(REG_PREDICT_ENABLE, 32'd0);
        for (int i = 0; i < 40; i++) pending_reqs.push_back(random_req());
        drain();
        reg_write(REG_PREDICT_ENABLE, 32'd1);
      end
    end

    $display("covered: directed corners, disabled phases, a long receiver hold-off, random mix");
    $display("%0d requests sent (%0d updates), %0d predictions checked, %0d mismatches",
             sent_count, updates_sent, predicts_seen, mismatches);
    if (mismatches == 0 && expected_preds.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
